// ===== rtl/tea_pkg.sv =====
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and round-sum functions for the TEA cipher pipeline
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int ROUNDS = 32;
  localparam int CELLS  = 2 * ROUNDS;
  localparam logic [31:0] DELTA = 32'h9e37_79b9;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD0_IDX = 8'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD1_IDX = 8'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD2_IDX = 8'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD3_IDX = 8'd3;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] block_word0;
    logic [31:0] block_word1;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_word0;
    logic [31:0] result_word1;
  } out_word_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } key_t;

  // word in flight between cells
  typedef struct packed {
    logic        op;
    logic [31:0] x;
    logic [31:0] y;
  } cell_word_t;

  // round sum for encryption: (round + 1) * delta mod 2^32
  function automatic logic [31:0] enc_sum(input int round);
    logic [63:0] prod;
    prod = 64'(round + 1) * 64'(DELTA);
    return prod[31:0];
  endfunction

  // round sum for decryption: (ROUNDS - round) * delta mod 2^32
  function automatic logic [31:0] dec_sum(input int round);
    logic [63:0] prod;
    prod = 64'(ROUNDS - round) * 64'(DELTA);
    return prod[31:0];
  endfunction

endpackage

// ===== rtl/tea_cell.sv =====
// ----------------------------------------------------------------------------
// tea_cell
// One half-round of TEA: a single mix and add/subtract, registered
// ----------------------------------------------------------------------------
module tea_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               half,
  input  logic [31:0]        enc_sum,
  input  logic [31:0]        dec_sum,
  input  tea_pkg::key_t      key,
  input  logic               in_valid,
  input  tea_pkg::cell_word_t in_data,
  output logic               out_valid,
  output tea_pkg::cell_word_t out_data
);
  import tea_pkg::*;

  logic        src_is_x;
  logic [31:0] src;
  logic [31:0] dst;
  logic [31:0] sum;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] mix;
  logic [31:0] dst_new;
  cell_word_t  data_next;

  always_comb begin
    // encrypt: first half updates x from y, second half y from x; decrypt mirrors
    src_is_x = half ^ in_data.op;
    src      = src_is_x ? in_data.x : in_data.y;
    dst      = src_is_x ? in_data.y : in_data.x;
    ka       = src_is_x ? key.k2 : key.k0;
    kb       = src_is_x ? key.k3 : key.k1;
    sum      = (in_data.op == OP_DECRYPT) ? dec_sum : enc_sum;
    mix      = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
    dst_new  = (in_data.op == OP_DECRYPT) ? (dst - mix) : (dst + mix);

    data_next    = in_data;
    if (src_is_x) begin
      data_next.y = dst_new;
    end else begin
      data_next.x = dst_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== rtl/tea_out_buf.sv =====
// ----------------------------------------------------------------------------
// tea_out_buf
// Output register with one skid entry, so the cell chain stalls on a flop
// ----------------------------------------------------------------------------
module tea_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  tea_pkg::out_word_t in_data,
  output logic               full,
  output logic               out_valid,
  output tea_pkg::out_word_t out_data,
  input  logic               out_stall
);
  import tea_pkg::*;

  out_word_t skid;
  logic      take;
  logic      pop;
  logic      load_out;

  assign take     = in_valid && !full;
  assign pop      = out_valid && !out_stall;
  // new word goes straight out when the output slot is free or draining
  assign load_out = take && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      full      <= 1'b0;
    end else if (full) begin
      if (pop) begin
        full <= 1'b0;
      end
    end else if (take) begin
      out_valid <= 1'b1;
      if (!load_out) begin
        full <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (full && pop) begin
      out_data <= skid;
    end else if (load_out) begin
      out_data <= in_data;
    end
    if (take && !load_out) begin
      skid <= in_data;
    end
  end

endmodule

// ===== rtl/tea_block_cipher.sv =====
// ----------------------------------------------------------------------------
// tea_block_cipher
// TEA encrypt/decrypt of 64-bit blocks under a 128-bit key, 32 rounds
// ----------------------------------------------------------------------------
// datapath: input accept, then 64 half-round cells, then the output register
// throughput: one block per cycle through the chain of half-round cells,
//   while the output skid entry is free
// reset: rst clears all valid flags and the key to zero; in-flight words drop
// ----------------------------------------------------------------------------
module tea_block_cipher (
  input  logic                              clk,
  input  logic                              rst,
  // input word channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tea_pkg::in_word_t                 in_data,
  // result word channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output tea_pkg::out_word_t                out_data,
  // key register write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tea_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import tea_pkg::*;

  key_t       key;
  logic       advance;
  logic       buf_full;
  out_word_t  chain_result;

  // chain taps: entry 0 is the input, entry CELLS the last cell
  logic       stage_valid [0:CELLS];
  cell_word_t stage_data  [0:CELLS];

  // key registers; writes to unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        KEY_WORD0_IDX: key.k0 <= cfg_data;
        KEY_WORD1_IDX: key.k1 <= cfg_data;
        KEY_WORD2_IDX: key.k2 <= cfg_data;
        KEY_WORD3_IDX: key.k3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole chain moves unless the output skid entry is occupied;
  // buf_full is a flop, so the stall never ripples through the cells
  assign advance  = !buf_full;
  assign in_stall = buf_full;

  // block word0 is the left half (x), word1 the right half (y)
  assign stage_valid[0]   = in_valid;
  assign stage_data[0].op = in_data.op;
  assign stage_data[0].x  = in_data.block_word0;
  assign stage_data[0].y  = in_data.block_word1;

  // two cells per round; the round sums are constants per cell
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    tea_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .half      (1'((i % 2))),
      .enc_sum   (enc_sum(i / 2)),
      .dec_sum   (dec_sum(i / 2)),
      .key       (key),
      .in_valid  (stage_valid[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  assign chain_result.result_word0 = stage_data[CELLS].x;
  assign chain_result.result_word1 = stage_data[CELLS].y;

  // output register plus skid entry
  tea_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[CELLS]),
    .in_data   (chain_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
